// ----- hw/rtl/ktmm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ktmm_pkg;

   localparam int unsigned NUM_KEYS     = 12;
   localparam logic [7:0]  DEBOUNCE_RST = 8'd100;
   localparam logic [13:0] LIMIT_MAX    = 14'd1023;

   // key_event codes
   localparam logic [1:0] EV_NONE  = 2'd0;
   localparam logic [1:0] EV_DIGIT = 2'd1;
   localparam logic [1:0] EV_CLEAR = 2'd2;
   localparam logic [1:0] EV_ENTER = 2'd3;

   // phase codes
   localparam logic [1:0] PH_LOWER   = 2'd0;
   localparam logic [1:0] PH_UPPER   = 2'd1;
   localparam logic [1:0] PH_MONITOR = 2'd2;
   localparam logic [1:0] PH_ERROR   = 2'd3;

   // level codes
   localparam logic [1:0] LV_NONE = 2'd0;
   localparam logic [1:0] LV_DRY  = 2'd1;
   localparam logic [1:0] LV_OK   = 2'd2;
   localparam logic [1:0] LV_WET  = 2'd3;

   // key codes above the digits
   localparam logic [3:0] KC_CLEAR = 4'd10;
   localparam logic [3:0] KC_ENTER = 4'd11;

   typedef struct packed {
      logic       valid;
      logic [3:0] idx;
   } key_lookup_type;

   // Keypad position to key slot. Rows 0..2 x columns 0..2 are digits 1..9;
   // row 3 has Clear, 0, unused, Enter.
   function automatic key_lookup_type key_lookup(input logic [1:0] row,
                                                 input logic [1:0] col);
      key_lookup_type r;
      r.valid = 1'b0;
      r.idx   = 4'd0;
      if (row != 2'd3) begin
         if (col != 2'd3) begin
            r.valid = 1'b1;
            r.idx   = 4'({2'b00, row} * 4'd3 + {2'b00, col});
         end
      end else begin
         case (col)
            2'd0: begin
               r.valid = 1'b1;
               r.idx   = 4'd9;
            end
            2'd1: begin
               r.valid = 1'b1;
               r.idx   = 4'd10;
            end
            2'd3: begin
               r.valid = 1'b1;
               r.idx   = 4'd11;
            end
            default: begin
               r.valid = 1'b0;
               r.idx   = 4'd0;
            end
         endcase
      end
      return r;
   endfunction

   // Key slot to key code: digits 0..9, Clear, Enter.
   function automatic logic [3:0] key_code(input logic [3:0] idx);
      logic [3:0] c;
      case (idx)
         4'd9:    c = KC_CLEAR;
         4'd10:   c = 4'd0;
         4'd11:   c = KC_ENTER;
         default: c = idx + 4'd1;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/keypad_threshold_moisture_monitor.sv -----
// Keypad threshold moisture monitor. Each transfer on the req_ channel is
// either a keypad scan tick (req_tuser = 0, column levels in req_tdata) or a
// moisture ADC sample (req_tuser = 1). Every accepted item yields exactly one
// rsp_ transfer, registered, in the cycle after acceptance; one item per clock
// is sustained, and a new item is taken while the previous result waits,
// as long as rsp_tready frees the result register. The 4x4 keypad is scanned
// one row per tick: drive rsp row_drive on the rows before the next tick. A
// new press holds the row for debounce_ticks ticks (csr_we / csr_wdata,
// reset 100, 0 acts as 1) and is then resampled. Digits build a number of
// up to MAX_DIGITS digits, Clear zeroes it, Enter stores the lower then the
// upper limit (swapped if needed; above 1023 gives the error phase). In the
// monitoring phase samples are classified dry / ok / wet, fan on when wet.
`timescale 1ns / 1ps
`default_nettype none

module keypad_threshold_moisture_monitor
   import ktmm_pkg::*;
#(
   parameter int unsigned MAX_DIGITS = 4   // 1..4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,     // [3:0] columns, [13:4] sample, [15:14] zero
   input  wire logic        req_tuser,     // [0] action: 0 scan tick, 1 ADC sample
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,     // [3:0] row_drive, [5:4] key_event,
                                           // [19:6] typed_value, [21:20] phase,
                                           // [23:22] level, [24] fan_on, [31:25] zero
   // configuration
   input  wire logic        csr_we,
   input  wire logic [7:0]  csr_wdata      // debounce_ticks
);

   localparam logic [2:0] MAX_DIGITS_W = 3'(MAX_DIGITS);

   // ---------------------------------------------------------------------
   // State
   // ---------------------------------------------------------------------
   logic [7:0]          debounce_ticks_ff;
   logic [1:0]          row_ff,       row_in;
   logic [NUM_KEYS-1:0] last_lvl_ff,  last_lvl_in;   // 1 = released
   logic [7:0]          dbc_ff,       dbc_in;        // 0 = not debouncing
   logic [1:0]          pend_col_ff,  pend_col_in;
   logic [2:0]          digits_ff,    digits_in;
   logic [13:0]         entry_ff,     entry_in;
   logic [13:0]         lower_ff,     lower_in;
   logic [13:0]         upper_ff,     upper_in;
   logic [1:0]          phase_ff,     phase_in;

   // result register
   logic                rsp_valid_ff;
   logic [31:0]         rsp_data_ff,  rsp_data_in;

   logic                accept;
   logic                action;
   logic [3:0]          cols;
   logic [9:0]          sample;

   assign action = req_tuser;
   assign cols   = req_tdata[3:0];
   assign sample = req_tdata[13:4];

   // Result register frees up on the same edge it is taken.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Next-state logic for one item
   // ---------------------------------------------------------------------
   always_comb begin
      logic [1:0]     ev;
      logic [1:0]     lvl;
      logic           fan;
      logic           hold;
      logic           do_scan;
      logic           stop;
      logic [2:0]     first;
      logic [7:0]     reload;
      logic [13:0]    sample_w;
      logic [3:0]     code;
      logic           lv;
      logic [3:0]     row_drive;
      logic [13:0]    shown;
      key_lookup_type kl;

      row_in      = row_ff;
      last_lvl_in = last_lvl_ff;
      dbc_in      = dbc_ff;
      pend_col_in = pend_col_ff;
      digits_in   = digits_ff;
      entry_in    = entry_ff;
      lower_in    = lower_ff;
      upper_in    = upper_ff;
      phase_in    = phase_ff;

      ev       = EV_NONE;
      lvl      = LV_NONE;
      fan      = 1'b0;
      hold     = 1'b0;
      do_scan  = 1'b0;
      stop     = 1'b0;
      first    = 3'd0;
      code     = 4'd0;
      lv       = 1'b1;
      kl       = '0;
      reload   = (debounce_ticks_ff == 8'd0) ? 8'd1 : debounce_ticks_ff;
      sample_w = {4'd0, sample};

      if (action) begin
         // ADC sample: classify only while monitoring
         if (phase_ff == PH_MONITOR) begin
            if (sample_w > upper_ff) begin
               lvl = LV_DRY;
            end else if (sample_w < lower_ff) begin
               lvl = LV_WET;
               fan = 1'b1;
            end else begin
               lvl = LV_OK;
            end
         end
      end else if (phase_ff == PH_LOWER || phase_ff == PH_UPPER) begin
         if (dbc_ff > 8'd1) begin
            dbc_in = dbc_ff - 8'd1;
            hold   = 1'b1;
         end else if (dbc_ff == 8'd1) begin
            // resample tick for the pending key
            dbc_in  = 8'd0;
            kl      = key_lookup(row_ff, pend_col_ff);
            lv      = cols[pend_col_ff];
            do_scan = 1'b1;
            first   = {1'b0, pend_col_ff} + 3'd1;
            if (kl.valid) begin
               last_lvl_in[kl.idx] = lv;
               if (!lv) begin
                  code = key_code(kl.idx);
                  if (code == KC_CLEAR) begin
                     ev        = EV_CLEAR;
                     entry_in  = 14'd0;
                     digits_in = 3'd0;
                  end else if (code == KC_ENTER) begin
                     ev        = EV_ENTER;
                     do_scan   = 1'b0;
                     entry_in  = 14'd0;
                     digits_in = 3'd0;
                     if (phase_ff == PH_LOWER) begin
                        lower_in = entry_ff;
                        phase_in = PH_UPPER;
                     end else begin
                        // store upper, swap when it sits below the lower limit
                        if (entry_ff < lower_ff) begin
                           upper_in = lower_ff;
                           lower_in = entry_ff;
                        end else begin
                           upper_in = entry_ff;
                        end
                        phase_in = (entry_ff > LIMIT_MAX || lower_ff > LIMIT_MAX) ?
                                   PH_ERROR : PH_MONITOR;
                     end
                  end else if (digits_ff < MAX_DIGITS_W) begin
                     ev        = EV_DIGIT;
                     entry_in  = 14'((entry_ff << 3) + (entry_ff << 1) + {10'd0, code});
                     digits_in = digits_ff + 3'd1;
                  end
               end
            end
         end else begin
            do_scan = 1'b1;
            first   = 3'd0;
         end

         // scan the rest of the row: releases update, first new press debounces
         if (do_scan) begin
            for (int c = 0; c < 4; c++) begin
               if (3'(c) >= first && !stop) begin
                  kl = key_lookup(row_ff, 2'(c));
                  if (kl.valid && (cols[c] != last_lvl_in[kl.idx])) begin
                     if (!cols[c]) begin
                        pend_col_in = 2'(c);
                        dbc_in      = reload;
                        stop        = 1'b1;
                        hold        = 1'b1;
                     end else begin
                        last_lvl_in[kl.idx] = 1'b1;
                     end
                  end
               end
            end
         end

         if (!hold) begin
            row_in = row_ff + 2'd1;
         end
      end

      // enter shows the number just stored, everything else the live entry
      shown = (ev == EV_ENTER) ? entry_ff : entry_in;

      if (phase_in == PH_LOWER || phase_in == PH_UPPER) begin
         row_drive = ~(4'd1 << row_in);
      end else begin
         row_drive = 4'hF;
      end

      rsp_data_in = {7'd0, fan, lvl, phase_in, shown, ev, row_drive};
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ticks_ff <= DEBOUNCE_RST;
         row_ff            <= 2'd0;
         last_lvl_ff       <= '1;
         dbc_ff            <= 8'd0;
         pend_col_ff       <= 2'd0;
         digits_ff         <= 3'd0;
         entry_ff          <= 14'd0;
         lower_ff          <= 14'd0;
         upper_ff          <= 14'd0;
         phase_ff          <= PH_LOWER;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_we) begin
            debounce_ticks_ff <= csr_wdata;
         end
         if (accept) begin
            row_ff       <= row_in;
            last_lvl_ff  <= last_lvl_in;
            dbc_ff       <= dbc_in;
            pend_col_ff  <= pend_col_in;
            digits_ff    <= digits_in;
            entry_ff     <= entry_in;
            lower_ff     <= lower_in;
            upper_ff     <= upper_in;
            phase_ff     <= phase_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/ktmm_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ktmm_checker
   import ktmm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [31:0] rsp_tdata
);

   logic [3:0] row_drive;
   logic [1:0] key_event;
   logic [1:0] phase;
   logic [1:0] level;
   logic       fan_on;

   assign row_drive = rsp_tdata[3:0];
   assign key_event = rsp_tdata[5:4];
   assign phase     = rsp_tdata[21:20];
   assign level     = rsp_tdata[23:22];
   assign fan_on    = rsp_tdata[24];

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // digits and clears only happen while limits are being entered
   a_key_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (key_event == EV_DIGIT || key_event == EV_CLEAR)
      |-> (phase == PH_LOWER || phase == PH_UPPER))
      else $error("digit or clear outside entry");

   // fan tracks the wet classification
   a_fan: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (fan_on == (level == LV_WET)))
      else $error("fan does not match level");

   // samples are classified only while monitoring
   a_level_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && level != LV_NONE |-> phase == PH_MONITOR)
      else $error("sample classified outside monitoring");

   // keypad rows are released once entry is over
   a_rows_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (phase == PH_MONITOR || phase == PH_ERROR) |-> row_drive == 4'hF)
      else $error("rows driven after entry");

endmodule

bind keypad_threshold_moisture_monitor ktmm_checker u_ktmm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
